[rtl/core/klp_pkg.sv]
// ----------------------------------------------------------------------------
// Key long-press detector package
// Shared constants, message codes, controller states and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package klp_pkg;

  // Number of keys tracked in the key table.
  localparam int unsigned NUM_KEYS = 32;
  // Width of a key index into the table.
  localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  // Width of the per-key round counter and of the threshold register.
  localparam int unsigned CNT_W = 4;
  // Width of the external key code field.
  localparam int unsigned CODE_W = 8;
  // Threshold value after reset.
  localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(3);

  // Message kinds carried on the result port.
  typedef enum logic [1:0] {
    KIND_DOWN       = 2'd0,
    KIND_UP         = 2'd1,
    KIND_LONG_UP    = 2'd2,
    KIND_LONG_PRESS = 2'd3
  } msg_kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SWEEP,
    ST_FLUSH
  } klp_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // Request taken: latch the event and restart the sweep.
    logic event_en;  // Apply the latched event to its key entry.
    logic sweep_en;  // Visit one key entry of the sweep.
    logic flush_en;  // Release the held-back message as last of round.
  } klp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // The sweep is on its final key entry.
  } klp_stat_t;

endpackage

[rtl/core/key_long_press_detector_core.sv]
// A request runs through an event step, a sweep of all 32 keys and a flush;
// busy is high during those steps and a new request is taken in the cycle after the flush.
// The core takes no new request while busy; the key table sweep visits one entry per cycle.
// A message strobes in the cycle after its successor is made; the last, in the cycle after flush.
// The receiver cannot stall; every strobe carries one message.
// Reset clears the key table, the controller and the threshold (to 3) at once.
// ----------------------------------------------------------------------------
// Key long-press detector core
// Top level: joins the sequencing controller to the key-table datapath.
// ----------------------------------------------------------------------------
module key_long_press_detector_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [klp_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       event_valid_i,
  input  logic [4:0]                 event_type_i,
  input  logic [klp_pkg::CODE_W-1:0] key_code_i,
  input  logic [1:0]                 key_value_i,
  output logic                       result_valid_o,
  output logic [1:0]                 message_kind_o,
  output logic [klp_pkg::CODE_W-1:0] message_key_o,
  output logic                       last_of_round_o
);
  import klp_pkg::*;

  klp_cmd_t  cmd;
  klp_stat_t stat;

  // Controller.
  klp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Datapath.
  klp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .event_valid_i   (event_valid_i),
    .event_type_i    (event_type_i),
    .key_code_i      (key_code_i),
    .key_value_i     (key_value_i),
    .result_valid_o  (result_valid_o),
    .message_kind_o  (message_kind_o),
    .message_key_o   (message_key_o),
    .last_of_round_o (last_of_round_o)
  );

endmodule

[rtl/core/klp_ctrl.sv]
// ----------------------------------------------------------------------------
// Key long-press detector controller
// Sequences one request through the event step, the key sweep and the final
// flush of the held-back message.
// ----------------------------------------------------------------------------
module klp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  klp_pkg::klp_stat_t stat_i,
  output klp_pkg::klp_cmd_t  cmd_o
);
  import klp_pkg::*;

  klp_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EVENT;
        end
      end
      ST_EVENT: begin
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (stat_i.sweep_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ST_EVENT: begin
        cmd_o.event_en = 1'b1;
      end
      ST_SWEEP: begin
        cmd_o.sweep_en = 1'b1;
      end
      ST_FLUSH: begin
        cmd_o.flush_en = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/klp_datapath.sv]
// ----------------------------------------------------------------------------
// Key long-press detector datapath
// Holds the threshold register, the latched event, the per-key table, the
// sweep index, a one-deep message hold stage and the result register.
// ----------------------------------------------------------------------------
module klp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  klp_pkg::klp_cmd_t              cmd_i,
  output klp_pkg::klp_stat_t             stat_o,
  input  logic                           cfg_we_i,
  input  logic [klp_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                           event_valid_i,
  input  logic [4:0]                     event_type_i,
  input  logic [klp_pkg::CODE_W-1:0]     key_code_i,
  input  logic [1:0]                     key_value_i,
  output logic                           result_valid_o,
  output logic [1:0]                     message_kind_o,
  output logic [klp_pkg::CODE_W-1:0]     message_key_o,
  output logic                           last_of_round_o
);
  import klp_pkg::*;

  logic [CNT_W-1:0]  thr_q;
  logic              ev_hit_q;
  logic              ev_press_q;
  logic [KEY_W-1:0]  ev_key_q;
  logic [KEY_W-1:0]  idx_q;
  logic              held_q [NUM_KEYS];
  logic [CNT_W-1:0]  cnt_q  [NUM_KEYS];

  logic              pend_vld_q;
  msg_kind_e         pend_kind_q;
  logic [KEY_W-1:0]  pend_key_q;

  logic              out_vld_q;
  msg_kind_e         out_kind_q;
  logic [KEY_W-1:0]  out_key_q;
  logic              out_last_q;

  logic              ev_hit;
  logic [KEY_W-1:0]  addr;
  logic              rd_held;
  logic [CNT_W-1:0]  rd_cnt;
  logic              reached;
  logic              msg_vld;
  msg_kind_e         msg_kind;
  logic              emit_pend;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // An event counts only if valid, not a sync event, and within the table.
  assign ev_hit = event_valid_i && (event_type_i != 5'd0)
                  && (key_code_i < CODE_W'(NUM_KEYS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_hit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      ev_hit_q <= ev_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ev_press_q <= (key_value_i != 2'd0);
      ev_key_q   <= key_code_i[KEY_W-1:0];
    end
  end

  // Sweep index restarts with every request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.sweep_en) begin
      idx_q <= idx_q + KEY_W'(1);
    end
  end

  assign stat_o.sweep_last = (idx_q == KEY_W'(NUM_KEYS - 1));

  // One table entry is read per cycle: the event key or the swept key.
  always_comb begin
    addr    = cmd_i.event_en ? ev_key_q : idx_q;
    rd_held = held_q[addr];
    rd_cnt  = cnt_q[addr];
    reached = (rd_cnt >= thr_q);
  end

  // Message produced in this cycle, if any.
  always_comb begin
    msg_vld  = (cmd_i.event_en && ev_hit_q) || (cmd_i.sweep_en && rd_held && reached);
    msg_kind = KIND_LONG_PRESS;
    if (cmd_i.event_en) begin
      if (ev_press_q) begin
        msg_kind = KIND_DOWN;
      end else if (reached) begin
        msg_kind = KIND_LONG_UP;
      end else begin
        msg_kind = KIND_UP;
      end
    end
  end

  // Key table update: events set or clear a key, the sweep counts held keys.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        held_q[i] <= 1'b0;
        cnt_q[i]  <= '0;
      end
    end else if (cmd_i.event_en && ev_hit_q) begin
      held_q[addr] <= ev_press_q;
      cnt_q[addr]  <= '0;
    end else if (cmd_i.sweep_en && rd_held && !reached) begin
      cnt_q[addr] <= rd_cnt + CNT_W'(1);
    end
  end

  // The newest message is held back until it is known whether it is the last.
  assign emit_pend = pend_vld_q && (msg_vld || cmd_i.flush_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= emit_pend;
      if (msg_vld) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.flush_en) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_vld) begin
      pend_kind_q <= msg_kind;
      pend_key_q  <= addr;
    end
    if (emit_pend) begin
      out_kind_q <= pend_kind_q;
      out_key_q  <= pend_key_q;
      out_last_q <= cmd_i.flush_en;
    end
  end

  // Result port.
  assign result_valid_o  = out_vld_q;
  assign message_kind_o  = out_kind_q;
  assign message_key_o   = CODE_W'(out_key_q);
  assign last_of_round_o = out_last_q;

`ifndef SYNTHESIS
  // A key that is not held always has a cleared counter.
  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.event_en || cmd_i.sweep_en) && !rd_held |-> rd_cnt == '0)
    else $error("Released key has a non-zero round counter.");

  // The last message of a round is followed by a quiet cycle.
  a_last_then_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_last_q |=> !out_vld_q)
    else $error("Result directly follows the last message of a round.");

  // The flush empties the hold stage.
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush_en |=> !pend_vld_q)
    else $error("Hold stage still full after the flush.");

  // The sweep starts from the first key after the event step.
  a_sweep_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.event_en |-> idx_q == '0 && !pend_vld_q)
    else $error("Sweep index or hold stage not cleared at the event step.");
`endif

endmodule

[tb/sv/tb_key_long_press_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key long-press detector core testbench
// Sends poll rounds (plain ticks, ignored events, presses and releases) to
// the core under random idle gaps and several threshold settings. A local
// key-table model predicts every message of each round, and the messages
// are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_key_long_press_detector_core;
  import klp_pkg::*;

  // Event type and key value codes used by the stimulus.
  localparam logic [4:0] TYPE_SYNC   = 5'd0;
  localparam logic [4:0] TYPE_KEY    = 5'd1;
  localparam logic [1:0] VAL_RELEASE = 2'd0;
  localparam logic [1:0] VAL_PRESS   = 2'd1;
  localparam logic [1:0] VAL_REPEAT  = 2'd2;
  // Cycles a round may still run after its last message, plus margin.
  localparam int unsigned SETTLE_CYCLES = 45;
  localparam int unsigned MAX_REPORTS = 10;

  // One poll round request, with the idle cycles to leave after it.
  typedef struct {
    logic                ev_valid;
    logic [4:0]          ev_type;
    logic [CODE_W-1:0]   code;
    logic [1:0]          value;
    int unsigned         gap;
  } poll_round_t;

  // One message of a round.
  typedef struct packed {
    msg_kind_e         kind;
    logic [CODE_W-1:0] key;
    logic              last;
  } klp_msg_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              cfg_we_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              event_valid_i = 1'b0;
  logic [4:0]        event_type_i = '0;
  logic [CODE_W-1:0] key_code_i = '0;
  logic [1:0]        key_value_i = '0;
  logic              result_valid_o;
  logic [1:0]        message_kind_o;
  logic [CODE_W-1:0] message_key_o;
  logic              last_of_round_o;

  poll_round_t pending_rounds[$];
  klp_msg_t    expected_msgs[$];

  // Key-table model: held flag, round counter and threshold.
  bit               key_held_m [NUM_KEYS];
  logic [CNT_W-1:0] key_rounds_m [NUM_KEYS];
  logic [CNT_W-1:0] long_thr_m;

  // Keys the stimulus believes are held, used to aim releases.
  bit  gen_held [NUM_KEYS];
  bit  no_idle = 1'b0;

  logic        req_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned rounds_done = 0;
  int unsigned msgs_checked = 0;
  int unsigned long_press_seen = 0;
  int unsigned long_up_seen = 0;
  int unsigned thr_settings = 1;

  key_long_press_detector_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .event_valid_i  (event_valid_i),
    .event_type_i   (event_type_i),
    .key_code_i     (key_code_i),
    .key_value_i    (key_value_i),
    .result_valid_o (result_valid_o),
    .message_kind_o (message_kind_o),
    .message_key_o  (message_key_o),
    .last_of_round_o(last_of_round_o)
  );

  // Free-running clock, 10 ns period.
  always #5 clk_i = ~clk_i;

  // Count a failure and describe the first few.
  function automatic void note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
  endfunction

  // Apply one round to the key-table model and queue the messages it makes.
  task automatic predict_round_messages(input poll_round_t r);
    klp_msg_t    round_msgs[$];
    klp_msg_t    m;
    int unsigned k;
    // The event, if it is a real key event on a tracked key.
    if (r.ev_valid && r.ev_type != TYPE_SYNC && r.code < NUM_KEYS) begin
      k = r.code;
      m.key = r.code;
      m.last = 1'b0;
      if (r.value != VAL_RELEASE) begin
        key_held_m[k] = 1'b1;
        key_rounds_m[k] = '0;
        m.kind = KIND_DOWN;
      end else begin
        m.kind = (key_rounds_m[k] >= long_thr_m) ? KIND_LONG_UP : KIND_UP;
        key_held_m[k] = 1'b0;
        key_rounds_m[k] = '0;
      end
      round_msgs.push_back(m);
    end
    // The sweep: count up held keys, or report those already long pressed.
    for (k = 0; k < NUM_KEYS; k++) begin
      if (key_held_m[k]) begin
        if (key_rounds_m[k] >= long_thr_m) begin
          m.kind = KIND_LONG_PRESS;
          m.key = CODE_W'(k);
          m.last = 1'b0;
          round_msgs.push_back(m);
        end else begin
          key_rounds_m[k] = key_rounds_m[k] + 1'b1;
        end
      end
    end
    if (round_msgs.size() > 0) begin
      round_msgs[round_msgs.size() - 1].last = 1'b1;
    end
    foreach (round_msgs[i]) expected_msgs.push_back(round_msgs[i]);
  endtask

  // Compare one message with the oldest expectation.
  task automatic check_message(input klp_msg_t got);
    klp_msg_t want;
    if (expected_msgs.size() == 0) begin
      note_mismatch($sformatf("unexpected message kind %0d key %0d last %0b",
                              got.kind, got.key, got.last));
    end else begin
      want = expected_msgs.pop_front();
      msgs_checked++;
      if (want.kind == KIND_LONG_PRESS) long_press_seen++;
      if (want.kind == KIND_LONG_UP) long_up_seen++;
      if (got.kind !== want.kind || got.key !== want.key || got.last !== want.last) begin
        note_mismatch($sformatf("exp kind %0d key %0d last %0b, got kind %0d key %0d last %0b",
                                want.kind, want.key, want.last,
                                got.kind, got.key, got.last));
      end
    end
  endtask

  // Monitor: track threshold writes, check messages, predict accepted rounds.
  always @(posedge clk_i or negedge rst_ni) begin
    poll_round_t r;
    klp_msg_t    got;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_held_m[k] = 1'b0;
        key_rounds_m[k] = '0;
      end
      long_thr_m = THR_RESET;
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (cfg_we_i) long_thr_m = cfg_wdata_i;
      if (result_valid_o) begin
        got.kind = msg_kind_e'(message_kind_o);
        got.key = message_key_o;
        got.last = last_of_round_o;
        check_message(got);
      end
      if (start && !busy) begin
        r.ev_valid = event_valid_i;
        r.ev_type = event_type_i;
        r.code = key_code_i;
        r.value = key_value_i;
        r.gap = 0;
        predict_round_messages(r);
        rounds_done++;
      end
    end
  end

  // Driver: holds a request until taken, then waits its idle gap (counted
  // only while the core is idle) before presenting the next one.
  always @(negedge clk_i) begin
    poll_round_t r;
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && !req_taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        if (!busy) gap_left <= gap_left - 1;
      end else if (pending_rounds.size() > 0) begin
        r = pending_rounds.pop_front();
        event_valid_i <= r.ev_valid;
        event_type_i <= r.ev_type;
        key_code_i <= r.code;
        key_value_i <= r.value;
        gap_left <= r.gap;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Queue one round and keep the stimulus view of held keys current.
  function automatic void add_round(input logic ev_valid, input logic [4:0] ev_type,
                                    input logic [CODE_W-1:0] code,
                                    input logic [1:0] value);
    poll_round_t r;
    r.ev_valid = ev_valid;
    r.ev_type = ev_type;
    r.code = code;
    r.value = value;
    r.gap = no_idle ? 0 : $urandom_range(0, 6);
    pending_rounds.push_back(r);
    if (ev_valid && ev_type != TYPE_SYNC && code < NUM_KEYS) begin
      gen_held[code] = (value != VAL_RELEASE);
    end
  endfunction

  function automatic void add_tick();
    add_round(1'b0, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
              2'($urandom_range(0, 2)));
  endfunction

  // Random rounds: mostly press/hold/release sequences on a few keys, with
  // ticks, sync events and out-of-range codes mixed in.
  task automatic run_random_phase(input int unsigned n_rounds);
    int unsigned held_keys[$];
    int unsigned pick;
    int unsigned key;
    for (int unsigned i = 0; i < n_rounds; i++) begin
      no_idle = (i >= 30 && i < 50);
      pick = $urandom_range(0, 99);
      key = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, NUM_KEYS - 1);
      held_keys.delete();
      foreach (gen_held[k]) if (gen_held[k]) held_keys.push_back(k);
      if (pick < 30) begin
        add_round(1'b1, 5'($urandom_range(1, 31)), CODE_W'(key),
                  2'($urandom_range(VAL_PRESS, VAL_REPEAT)));
      end else if (pick < 50) begin
        if (held_keys.size() > 0 && $urandom_range(0, 9) < 8) begin
          key = held_keys[$urandom_range(0, held_keys.size() - 1)];
        end
        add_round(1'b1, 5'($urandom_range(1, 31)), CODE_W'(key), VAL_RELEASE);
      end else if (pick < 80) begin
        add_tick();
      end else if (pick < 88) begin
        add_round(1'b1, TYPE_SYNC, CODE_W'($urandom_range(0, 255)),
                  2'($urandom_range(0, 2)));
      end else begin
        add_round(1'b1, 5'($urandom_range(0, 31)),
                  CODE_W'($urandom_range(NUM_KEYS, 255)), 2'($urandom_range(0, 2)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Wait until every queued round is taken and every message has come back.
  task automatic wait_drained();
    while (pending_rounds.size() != 0 || start || expected_msgs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [CNT_W-1:0] thr);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_settings++;
  endtask

  // Stimulus sequence and final verdict.
  initial begin
    foreach (gen_held[k]) gen_held[k] = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed rounds at the reset threshold of three.
    add_round(1'b0, TYPE_SYNC, 8'd0, VAL_RELEASE);
    add_round(1'b1, TYPE_SYNC, 8'd4, VAL_PRESS);
    add_round(1'b0, 5'd31, 8'd4, VAL_PRESS);
    add_round(1'b1, TYPE_KEY, 8'(NUM_KEYS), VAL_PRESS);
    add_round(1'b1, 5'd31, 8'd255, VAL_REPEAT);
    add_round(1'b1, TYPE_KEY, 8'd7, VAL_RELEASE);
    add_round(1'b1, TYPE_KEY, 8'd0, VAL_PRESS);
    repeat (3) add_tick();
    add_round(1'b1, TYPE_KEY, 8'd0, VAL_RELEASE);
    add_round(1'b1, 5'd30, 8'(NUM_KEYS - 1), VAL_REPEAT);
    add_tick();
    add_round(1'b1, TYPE_KEY, 8'(NUM_KEYS - 1), VAL_PRESS);
    add_round(1'b1, 5'd17, 8'(NUM_KEYS - 1), VAL_RELEASE);
    add_round(1'b1, TYPE_KEY, 8'd1, VAL_PRESS);
    add_round(1'b1, 5'd14, 8'd30, VAL_PRESS);
    repeat (4) add_tick();
    add_round(1'b1, TYPE_KEY, 8'd1, VAL_RELEASE);
    add_round(1'b1, TYPE_KEY, 8'd30, VAL_RELEASE);
    wait_drained();

    // Random phases over the threshold extremes, zero, random values and the reset value.
    write_threshold(4'd1);
    run_random_phase(80);
    wait_drained();
    write_threshold(4'd15);
    run_random_phase(90);
    wait_drained();
    write_threshold(4'd0);
    run_random_phase(70);
    wait_drained();
    write_threshold(CNT_W'($urandom_range(1, 15)));
    run_random_phase(90);
    wait_drained();
    write_threshold(CNT_W'($urandom_range(2, 14)));
    run_random_phase(90);
    wait_drained();
    write_threshold(THR_RESET);
    run_random_phase(60);
    wait_drained();

    // Anything still expected never arrived.
    while (expected_msgs.size() > 0) begin
      void'(expected_msgs.pop_front());
      note_mismatch("expected message never arrived");
    end

    $display("Ran %0d poll rounds over %0d threshold settings; checked %0d messages",
             rounds_done, thr_settings, msgs_checked);
    $display("including %0d long press and %0d long release messages; %0d mismatches",
             long_press_seen, long_up_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung core.
  initial begin
    #3000000;
    $display("Watchdog expired with %0d messages outstanding", expected_msgs.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
